[rtl/core/pat_pkg.sv]
// ----------------------------------------------------------------------------
// pat_pkg
// Shared widths, codes and default sizes for the automation point table.
// ----------------------------------------------------------------------------
`default_nettype none

package pat_pkg;

  // field widths of the input and result words
  localparam int MODE_W   = 2;
  localparam int ID_W     = 32;
  localparam int OFF_W    = 16;
  localparam int VAL_W    = 64;
  localparam int SEL_W    = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // default table sizes
  localparam int DEF_MAX_SLOTS  = 16;
  localparam int DEF_MAX_POINTS = 16;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

endpackage

`default_nettype wire

[rtl/core/pat_if.sv]
// ----------------------------------------------------------------------------
// pat_in_if / pat_out_if
// Valid/ready channels that carry the request word and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface pat_in_if;
  logic                          valid;
  logic                          ready;
  logic [pat_pkg::MODE_W-1:0]    mode;
  logic [pat_pkg::ID_W-1:0]      param_id;
  logic [pat_pkg::OFF_W-1:0]     sample_offset;
  logic [pat_pkg::VAL_W-1:0]     value_bits;
  logic [pat_pkg::SEL_W-1:0]     slot_select;
  logic [pat_pkg::SEL_W-1:0]     point_select;

  modport source (output valid, mode, param_id, sample_offset, value_bits,
                  slot_select, point_select, input ready);
  modport sink   (input valid, mode, param_id, sample_offset, value_bits,
                  slot_select, point_select, output ready);
endinterface

interface pat_out_if;
  logic                          valid;
  logic                          ready;
  logic [pat_pkg::STATUS_W-1:0]  status;
  logic [pat_pkg::SEL_W-1:0]     slot_index;
  logic [pat_pkg::SEL_W-1:0]     point_index;
  logic [pat_pkg::ID_W-1:0]      read_param_id;
  logic [pat_pkg::OFF_W-1:0]     read_offset;
  logic [pat_pkg::VAL_W-1:0]     read_value;
  logic [pat_pkg::COUNT_W-1:0]   slots_used;
  logic [pat_pkg::COUNT_W-1:0]   points_in_slot;

  modport source (output valid, status, slot_index, point_index, read_param_id,
                  read_offset, read_value, slots_used, points_in_slot,
                  input ready);
  modport sink   (input valid, status, slot_index, point_index, read_param_id,
                  read_offset, read_value, slots_used, points_in_slot,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/pat_slot_mem.sv]
// ----------------------------------------------------------------------------
// pat_slot_mem
// Slot directory: parameter id and point count per slot, one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pat_slot_mem #(
  parameter int MAX_SLOTS = pat_pkg::DEF_MAX_SLOTS,
  parameter int CW        = pat_pkg::COUNT_W,
  localparam int SW       = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
  input  wire logic                       clk,
  input  wire logic [SW-1:0]              rd_addr,
  output logic      [pat_pkg::ID_W-1:0]   rd_id,
  output logic      [CW-1:0]              rd_cnt,
  input  wire logic [SW-1:0]              wr_addr,
  input  wire logic                       id_we,
  input  wire logic [pat_pkg::ID_W-1:0]   wr_id,
  input  wire logic                       cnt_we,
  input  wire logic [CW-1:0]              wr_cnt
);

  logic [pat_pkg::ID_W-1:0] id_mem  [MAX_SLOTS];
  logic [CW-1:0]            cnt_mem [MAX_SLOTS];

  // writes
  always_ff @(posedge clk) begin
    if (id_we) begin
      id_mem[wr_addr] <= wr_id;
    end
    if (cnt_we) begin
      cnt_mem[wr_addr] <= wr_cnt;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_id  <= id_mem[rd_addr];
    rd_cnt <= cnt_mem[rd_addr];
  end

endmodule

`default_nettype wire

[rtl/core/pat_point_mem.sv]
// ----------------------------------------------------------------------------
// pat_point_mem
// Point store: sample offset and value per point, one write and one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pat_point_mem #(
  parameter int DEPTH = pat_pkg::DEF_MAX_SLOTS * pat_pkg::DEF_MAX_POINTS,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                       clk,
  input  wire logic [AW-1:0]              rd_addr,
  output logic      [pat_pkg::OFF_W-1:0]  rd_off,
  output logic      [pat_pkg::VAL_W-1:0]  rd_val,
  input  wire logic                       we,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [pat_pkg::OFF_W-1:0]  wr_off,
  input  wire logic [pat_pkg::VAL_W-1:0]  wr_val
);

  logic [pat_pkg::OFF_W-1:0] off_mem [DEPTH];
  logic [pat_pkg::VAL_W-1:0] val_mem [DEPTH];

  // write
  always_ff @(posedge clk) begin
    if (we) begin
      off_mem[wr_addr] <= wr_off;
      val_mem[wr_addr] <= wr_val;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_off <= off_mem[rd_addr];
    rd_val <= val_mem[rd_addr];
  end

endmodule

`default_nettype wire

[rtl/core/param_automation_point_table.sv]
// Sequence: an add compares slot ids one by one, then scans points and shifts the
//   tail up; a read checks the slot select, then the slot metadata, then reads the
//   point; a clear empties the table directly
// Throughput: one word at a time; the next word is taken the cycle after the
//   result register loads, set by the sequencer on the single memory read ports
// Reset: synchronous active-low rst_n empties the table and drops any pending result
// ----------------------------------------------------------------------------
// param_automation_point_table
// Per-parameter automation point lists kept sorted by sample offset, with
// insert-or-update, indexed read and clear.
// ----------------------------------------------------------------------------
`default_nettype none

module param_automation_point_table #(
  parameter int MAX_SLOTS  = pat_pkg::DEF_MAX_SLOTS,
  parameter int MAX_POINTS = pat_pkg::DEF_MAX_POINTS
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pat_in_if.sink     in_chan,
  pat_out_if.source  out_chan
);

  localparam int SW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int SCW   = $clog2(MAX_SLOTS + 1);
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int DEPTH = MAX_SLOTS * MAX_POINTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_ID_RD    = 11'b000_0000_0010,
    S_ID_CMP   = 11'b000_0000_0100,
    S_PT_RD    = 11'b000_0000_1000,
    S_PT_CMP   = 11'b000_0001_0000,
    S_SH_RD    = 11'b000_0010_0000,
    S_SH_WR    = 11'b000_0100_0000,
    S_META_CHK = 11'b000_1000_0000,
    S_RD_PT    = 11'b001_0000_0000,
    S_DONE     = 11'b010_0000_0000,
    S_SPARE    = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // latched request word
  logic [pat_pkg::ID_W-1:0]  id_r;
  logic [pat_pkg::OFF_W-1:0] off_r;
  logic [pat_pkg::VAL_W-1:0] val_r;
  logic [pat_pkg::SEL_W-1:0] ssel_r;
  logic [pat_pkg::SEL_W-1:0] psel_r;

  // working registers
  logic [SCW-1:0] slot_count_r, slot_count_nxt;
  logic [SCW-1:0] idx_r, idx_nxt;
  logic [CW-1:0]  n_r, n_nxt;
  logic [CW-1:0]  pos_r, pos_nxt;
  logic [CW-1:0]  k_r, k_nxt;
  logic [AW-1:0]  base_r, base_nxt;

  // pending result
  logic [pat_pkg::STATUS_W-1:0] res_st_r, res_st_nxt;
  logic [pat_pkg::SEL_W-1:0]    res_si_r, res_si_nxt;
  logic [pat_pkg::SEL_W-1:0]    res_pi_r, res_pi_nxt;
  logic [pat_pkg::ID_W-1:0]     res_id_r, res_id_nxt;
  logic [pat_pkg::OFF_W-1:0]    res_off_r, res_off_nxt;
  logic [pat_pkg::VAL_W-1:0]    res_val_r, res_val_nxt;
  logic [pat_pkg::COUNT_W-1:0]  res_pc_r, res_pc_nxt;

  // output register
  logic                         out_valid_r;
  logic [pat_pkg::STATUS_W-1:0] out_st_r;
  logic [pat_pkg::SEL_W-1:0]    out_si_r;
  logic [pat_pkg::SEL_W-1:0]    out_pi_r;
  logic [pat_pkg::ID_W-1:0]     out_id_r;
  logic [pat_pkg::OFF_W-1:0]    out_off_r;
  logic [pat_pkg::VAL_W-1:0]    out_val_r;
  logic [pat_pkg::COUNT_W-1:0]  out_su_r;
  logic [pat_pkg::COUNT_W-1:0]  out_pc_r;

  // memory ports
  logic [SW-1:0]             sm_rd_addr, sm_wr_addr;
  logic [pat_pkg::ID_W-1:0]  sm_rd_id;
  logic [CW-1:0]             sm_rd_cnt, sm_wr_cnt;
  logic                      sm_id_we, sm_cnt_we;
  logic [AW-1:0]             pm_rd_addr, pm_wr_addr;
  logic [pat_pkg::OFF_W-1:0] pm_rd_off, pm_wr_off;
  logic [pat_pkg::VAL_W-1:0] pm_rd_val, pm_wr_val;
  logic                      pm_we;

  logic in_fire, out_load;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_load      = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  pat_slot_mem #(.MAX_SLOTS(MAX_SLOTS), .CW(CW)) u_slot_mem (
    .clk     (clk),
    .rd_addr (sm_rd_addr),
    .rd_id   (sm_rd_id),
    .rd_cnt  (sm_rd_cnt),
    .wr_addr (sm_wr_addr),
    .id_we   (sm_id_we),
    .wr_id   (id_r),
    .cnt_we  (sm_cnt_we),
    .wr_cnt  (sm_wr_cnt)
  );

  pat_point_mem #(.DEPTH(DEPTH)) u_point_mem (
    .clk     (clk),
    .rd_addr (pm_rd_addr),
    .rd_off  (pm_rd_off),
    .rd_val  (pm_rd_val),
    .we      (pm_we),
    .wr_addr (pm_wr_addr),
    .wr_off  (pm_wr_off),
    .wr_val  (pm_wr_val)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    slot_count_nxt = slot_count_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    pos_nxt        = pos_r;
    k_nxt          = k_r;
    base_nxt       = base_r;
    res_st_nxt     = res_st_r;
    res_si_nxt     = res_si_r;
    res_pi_nxt     = res_pi_r;
    res_id_nxt     = res_id_r;
    res_off_nxt    = res_off_r;
    res_val_nxt    = res_val_r;
    res_pc_nxt     = res_pc_r;
    sm_rd_addr     = SW'(idx_r);
    sm_wr_addr     = SW'(idx_r);
    sm_id_we       = 1'b0;
    sm_cnt_we      = 1'b0;
    sm_wr_cnt      = '0;
    pm_rd_addr     = base_r + AW'(pos_r);
    pm_wr_addr     = base_r + AW'(pos_r);
    pm_wr_off      = off_r;
    pm_wr_val      = val_r;
    pm_we          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        sm_rd_addr  = SW'(in_chan.slot_select);
        res_id_nxt  = '0;
        res_off_nxt = '0;
        res_val_nxt = '0;
        res_si_nxt  = '0;
        res_pi_nxt  = '0;
        res_pc_nxt  = '0;
        if (in_fire) begin
          unique case (in_chan.mode)
            pat_pkg::MODE_ADD: begin
              idx_nxt   = '0;
              state_nxt = S_ID_RD;
            end
            pat_pkg::MODE_READ: begin
              res_si_nxt = in_chan.slot_select;
              res_pi_nxt = in_chan.point_select;
              if (32'(in_chan.slot_select) >= 32'(slot_count_r)) begin
                res_st_nxt = pat_pkg::ST_BAD;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_META_CHK;
              end
            end
            pat_pkg::MODE_CLEAR: begin
              slot_count_nxt = '0;
              res_st_nxt     = pat_pkg::ST_OK;
              state_nxt      = S_DONE;
            end
            default: begin
              res_st_nxt = pat_pkg::ST_BAD;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end

      // walk the slot directory
      S_ID_RD: begin
        if (idx_r >= slot_count_r) begin
          if (32'(slot_count_r) >= MAX_SLOTS) begin
            res_st_nxt = pat_pkg::ST_FULL;
            state_nxt  = S_DONE;
          end else begin
            // append a new slot
            sm_wr_addr     = SW'(slot_count_r);
            sm_id_we       = 1'b1;
            sm_cnt_we      = 1'b1;
            sm_wr_cnt      = '0;
            idx_nxt        = slot_count_r;
            slot_count_nxt = slot_count_r + SCW'(1);
            n_nxt          = '0;
            pos_nxt        = '0;
            base_nxt       = AW'(32'(slot_count_r) * MAX_POINTS);
            state_nxt      = S_PT_RD;
          end
        end else begin
          state_nxt = S_ID_CMP;
        end
      end

      S_ID_CMP: begin
        if (sm_rd_id == id_r) begin
          n_nxt     = sm_rd_cnt;
          pos_nxt   = '0;
          base_nxt  = AW'(32'(idx_r) * MAX_POINTS);
          state_nxt = S_PT_RD;
        end else begin
          idx_nxt   = idx_r + SCW'(1);
          state_nxt = S_ID_RD;
        end
      end

      // scan the sorted list for the insert position
      S_PT_RD: begin
        res_si_nxt = 4'(idx_r);
        if (pos_r >= n_r) begin
          if (32'(n_r) >= MAX_POINTS) begin
            res_st_nxt = pat_pkg::ST_FULL;
            res_pc_nxt = 5'(n_r);
            state_nxt  = S_DONE;
          end else begin
            k_nxt     = n_r;
            state_nxt = S_SH_RD;
          end
        end else begin
          state_nxt = S_PT_CMP;
        end
      end

      S_PT_CMP: begin
        if (pm_rd_off < off_r) begin
          pos_nxt   = pos_r + CW'(1);
          state_nxt = S_PT_RD;
        end else if (pm_rd_off == off_r) begin
          // same offset: overwrite the value
          pm_we      = 1'b1;
          res_st_nxt = pat_pkg::ST_OK;
          res_pi_nxt = 4'(pos_r);
          res_pc_nxt = 5'(n_r);
          state_nxt  = S_DONE;
        end else if (32'(n_r) >= MAX_POINTS) begin
          res_st_nxt = pat_pkg::ST_FULL;
          res_pc_nxt = 5'(n_r);
          state_nxt  = S_DONE;
        end else begin
          k_nxt     = n_r;
          state_nxt = S_SH_RD;
        end
      end

      // move the tail up one place, then drop the new point in
      S_SH_RD: begin
        pm_rd_addr = base_r + AW'(k_r) - AW'(1);
        if (k_r > pos_r) begin
          state_nxt = S_SH_WR;
        end else begin
          pm_we      = 1'b1;
          sm_cnt_we  = 1'b1;
          sm_wr_cnt  = n_r + CW'(1);
          res_st_nxt = pat_pkg::ST_OK;
          res_pi_nxt = 4'(pos_r);
          res_pc_nxt = 5'(n_r + CW'(1));
          state_nxt  = S_DONE;
        end
      end

      S_SH_WR: begin
        pm_we      = 1'b1;
        pm_wr_addr = base_r + AW'(k_r);
        pm_wr_off  = pm_rd_off;
        pm_wr_val  = pm_rd_val;
        k_nxt      = k_r - CW'(1);
        state_nxt  = S_SH_RD;
      end

      // read: slot metadata is back
      S_META_CHK: begin
        n_nxt      = sm_rd_cnt;
        res_id_nxt = sm_rd_id;
        res_pc_nxt = 5'(sm_rd_cnt);
        pm_rd_addr = AW'(32'(ssel_r) * MAX_POINTS + 32'(psel_r));
        if (32'(psel_r) >= 32'(sm_rd_cnt)) begin
          res_st_nxt = pat_pkg::ST_BAD;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_RD_PT;
        end
      end

      S_RD_PT: begin
        res_st_nxt  = pat_pkg::ST_OK;
        res_off_nxt = pm_rd_off;
        res_val_nxt = pm_rd_val;
        state_nxt   = S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_count_r <= slot_count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      id_r   <= in_chan.param_id;
      off_r  <= in_chan.sample_offset;
      val_r  <= in_chan.value_bits;
      ssel_r <= in_chan.slot_select;
      psel_r <= in_chan.point_select;
    end
    idx_r     <= idx_nxt;
    n_r       <= n_nxt;
    pos_r     <= pos_nxt;
    k_r       <= k_nxt;
    base_r    <= base_nxt;
    res_st_r  <= res_st_nxt;
    res_si_r  <= res_si_nxt;
    res_pi_r  <= res_pi_nxt;
    res_id_r  <= res_id_nxt;
    res_off_r <= res_off_nxt;
    res_val_r <= res_val_nxt;
    res_pc_r  <= res_pc_nxt;
    if (out_load) begin
      out_st_r  <= res_st_r;
      out_si_r  <= res_si_r;
      out_pi_r  <= res_pi_r;
      out_id_r  <= res_id_r;
      out_off_r <= res_off_r;
      out_val_r <= res_val_r;
      out_su_r  <= 5'(slot_count_r);
      out_pc_r  <= res_pc_r;
    end
  end

  // result word
  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = out_st_r;
  assign out_chan.slot_index     = out_si_r;
  assign out_chan.point_index    = out_pi_r;
  assign out_chan.read_param_id  = out_id_r;
  assign out_chan.read_offset    = out_off_r;
  assign out_chan.read_value     = out_val_r;
  assign out_chan.slots_used     = out_su_r;
  assign out_chan.points_in_slot = out_pc_r;

  // checks
  a_slot_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    32'(slot_count_r) <= MAX_SLOTS)
    else $error("slot count beyond table size");

  a_point_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PT_RD) |-> (32'(n_r) <= MAX_POINTS))
    else $error("point count beyond list size");

  a_shift_above_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SH_WR) |-> (k_r > pos_r))
    else $error("shift below insert position");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not presented after completion");

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pm_we |-> (32'(pm_wr_addr) < DEPTH))
    else $error("point write outside store");

endmodule

`default_nettype wire
